// ===== rtl/sxfb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxfb_pkg: shared types and constants of the sprite XOR frame buffer
// Frame geometry, request codes, wrap tables and the row store write bundle.
// ----------------------------------------------------------------------------
package sxfb_pkg;

    localparam int FRAME_WIDTH  = 64;
    localparam int FRAME_HEIGHT = 32;
    localparam int SPRITE_BITS  = 8;
    localparam int PIX_W        = 64;
    // wrapped y position plus row offset: up to 31 + 15 (wrapped x: up to 63)
    localparam int POS_W        = 7;
    localparam int ROW_W        = $clog2(FRAME_HEIGHT);

    // columns at or past the frame width never hold a lit pixel
    localparam logic [PIX_W-1:0] WIDTH_MASK = ~({PIX_W{1'b1}} >> FRAME_WIDTH);

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    typedef logic [POS_W-1:0] t_pos_tab [256];

    typedef struct packed {
        logic             clear;
        logic             wr_en;
        logic [ROW_W-1:0] row;
        logic [PIX_W-1:0] data;
    } t_store_wr;

    function automatic t_pos_tab f_x_wrap_tab();
        t_pos_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = POS_W'(i % FRAME_WIDTH);
        end
        return tab;
    endfunction

    function automatic t_pos_tab f_y_wrap_tab();
        t_pos_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = POS_W'(i % FRAME_HEIGHT);
        end
        return tab;
    endfunction

    localparam t_pos_tab X_WRAP = f_x_wrap_tab();
    localparam t_pos_tab Y_WRAP = f_y_wrap_tab();

endpackage

// ===== rtl/sprite_xor_frame_buffer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sprite_xor_frame_buffer: monochrome XOR sprite frame buffer
// Clears, draws 8-pixel sprite rows by XOR and reads back whole rows.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel  (i_valid / o_ready) carries one request word: clear,
//   draw one sprite row, or read one frame row. Output channel
//   (o_valid / i_ready) returns exactly one result word per request:
//   o_collision on a draw, o_pixel_row on a read, zero in fields that do
//   not apply to the request.
//   Path: an accepted word goes from the input register into the result
//   register, which drives o_valid. Throughput: one word per cycle unless
//   the output stalls. The row store read, sprite XOR and write-back sit
//   between the input register and the result register, so
//   back-to-back draws to the same row see each other's updates.
//   Reset: synchronous, active low. Drops both pipeline valids, darkens the
//   whole frame at once (row valid bits) and clears the collision flag.
//   Stall: while the result waits on i_ready the input register holds its
//   word; o_ready then falls until the result is taken.
//   i_last_row is informational: the draw result on that row is the
//   sprite's final collision flag.
// ----------------------------------------------------------------------------
module sprite_xor_frame_buffer (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [1:0]                   i_req_type,
    input  logic [7:0]                   i_start_x,
    input  logic [7:0]                   i_start_y,
    input  logic [3:0]                   i_row_offset,
    input  logic [7:0]                   i_sprite_byte,
    input  logic                         i_last_row,
    input  logic [4:0]                   i_read_row,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_collision,
    output logic [63:0]                  o_pixel_row
);
    import sxfb_pkg::*;

    // input register
    logic                   r_iv;
    logic [1:0]             r_req;
    logic [7:0]             r_sx;
    logic [7:0]             r_sy;
    logic [3:0]             r_off;
    logic [SPRITE_BITS-1:0] r_byte;
    logic [4:0]             r_rr;

    // result register
    logic                   r_ov;
    logic                   r_coll;
    logic [PIX_W-1:0]       r_pix;

    // sprite collision flag
    logic                   r_flag;

    logic                   fire;
    logic                   in_take;
    logic [ROW_W-1:0]       rd_row;
    logic [PIX_W-1:0]       rd_data;
    t_store_wr              wr;
    t_store_wr              wr_gated;
    logic                   n_flag;
    logic                   n_coll;
    logic [PIX_W-1:0]       n_pix;

    // advance the held word when the result register is free or being drained
    assign fire    = r_iv && (!r_ov || i_ready);
    assign o_ready = !r_iv || fire;
    assign in_take = i_valid && o_ready;

    // state changes only when the word really moves on
    assign wr_gated = fire ? wr : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv   <= 1'b0;
            r_ov   <= 1'b0;
            r_flag <= 1'b0;
        end else begin
            if (in_take) begin
                r_iv <= 1'b1;
            end else if (fire) begin
                r_iv <= 1'b0;
            end
            if (fire) begin
                r_ov   <= 1'b1;
                r_flag <= n_flag;
            end else if (i_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // payload: hold on stall, load on accept
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_req  <= i_req_type;
            r_sx   <= i_start_x;
            r_sy   <= i_start_y;
            r_off  <= i_row_offset;
            r_byte <= i_sprite_byte;
            r_rr   <= i_read_row;
        end
        if (fire) begin
            r_coll <= n_coll;
            r_pix  <= n_pix;
        end
    end

    sxfb_draw_unit u_draw (
        .i_req_type   (r_req),
        .i_start_x    (r_sx),
        .i_start_y    (r_sy),
        .i_row_offset (r_off),
        .i_sprite_byte(r_byte),
        .i_read_row   (r_rr),
        .i_flag       (r_flag),
        .i_rd_data    (rd_data),
        .o_rd_row     (rd_row),
        .o_wr         (wr),
        .o_flag_nxt   (n_flag),
        .o_collision  (n_coll),
        .o_pixel_row  (n_pix)
    );

    sxfb_row_store u_store (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (wr_gated),
        .i_rd_row (rd_row),
        .o_rd_data(rd_data)
    );

    assign o_valid     = r_ov;
    assign o_collision = r_coll;
    assign o_pixel_row = r_pix;

endmodule

// ===== rtl/sxfb_row_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxfb_row_store: frame row storage
// One row per entry with a valid bit each; a row that is not valid reads as
// dark. Clear drops all valid bits together.
// ----------------------------------------------------------------------------
module sxfb_row_store (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  sxfb_pkg::t_store_wr        i_wr,
    input  logic [sxfb_pkg::ROW_W-1:0] i_rd_row,
    output logic [sxfb_pkg::PIX_W-1:0] o_rd_data
);
    import sxfb_pkg::*;

    logic [PIX_W-1:0]        r_rows [FRAME_HEIGHT];
    logic [FRAME_HEIGHT-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.clear) begin
            r_valid <= '0;
        end else if (i_wr.wr_en) begin
            r_valid[i_wr.row] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_en && !i_wr.clear) begin
            r_rows[i_wr.row] <= i_wr.data;
        end
    end

    assign o_rd_data = r_valid[i_rd_row] ? r_rows[i_rd_row] : '0;

endmodule

// ===== rtl/sxfb_draw_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxfb_draw_unit: request decode and sprite row XOR
// Wraps the start position, builds the clipped sprite mask, XORs it into the
// addressed row and forms the collision flag and the read result.
// ----------------------------------------------------------------------------
module sxfb_draw_unit (
    input  logic [1:0]                   i_req_type,
    input  logic [7:0]                   i_start_x,
    input  logic [7:0]                   i_start_y,
    input  logic [3:0]                   i_row_offset,
    input  logic [sxfb_pkg::SPRITE_BITS-1:0] i_sprite_byte,
    input  logic [4:0]                   i_read_row,
    input  logic                         i_flag,
    input  logic [sxfb_pkg::PIX_W-1:0]   i_rd_data,
    output logic [sxfb_pkg::ROW_W-1:0]   o_rd_row,
    output sxfb_pkg::t_store_wr          o_wr,
    output logic                         o_flag_nxt,
    output logic                         o_collision,
    output logic [sxfb_pkg::PIX_W-1:0]   o_pixel_row
);
    import sxfb_pkg::*;

    logic [POS_W-1:0] x0;
    logic [POS_W-1:0] y;
    logic             y_in;
    logic [POS_W-1:0] rr;
    logic             rr_in;
    logic [PIX_W-1:0] spr;
    logic             flag_base;

    always_comb begin
        x0    = X_WRAP[i_start_x];
        y     = Y_WRAP[i_start_y] + POS_W'(i_row_offset);
        y_in  = y < POS_W'(FRAME_HEIGHT);
        rr    = POS_W'(i_read_row);
        rr_in = rr < POS_W'(FRAME_HEIGHT);
        // leftmost sprite pixel lands on bit 63 - x0; pixels past the edge drop
        spr   = ({i_sprite_byte, {(PIX_W-SPRITE_BITS){1'b0}}} >> x0) & WIDTH_MASK;
        flag_base = (i_row_offset == 4'd0) ? 1'b0 : i_flag;

        o_rd_row    = y[ROW_W-1:0];
        o_wr        = '0;
        o_flag_nxt  = i_flag;
        o_collision = 1'b0;
        o_pixel_row = '0;

        unique case (t_req'(i_req_type))
            REQ_CLEAR: begin
                o_wr.clear = 1'b1;
            end
            REQ_DRAW: begin
                o_flag_nxt  = flag_base | (y_in && ((i_rd_data & spr) != '0));
                o_collision = o_flag_nxt;
                o_wr.wr_en  = y_in;
                o_wr.row    = y[ROW_W-1:0];
                o_wr.data   = i_rd_data ^ spr;
            end
            REQ_READ: begin
                o_rd_row    = rr[ROW_W-1:0];
                o_pixel_row = rr_in ? i_rd_data : '0;
            end
            default: begin
                o_wr = '0;
            end
        endcase
    end

endmodule

// ===== rtl/sxfb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sxfb_checker: port-level checks of the sprite XOR frame buffer
// Watches reset, pipeline progress, back pressure and frame width clipping.
// ----------------------------------------------------------------------------
module sxfb_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         o_ready,
    input  logic                         o_valid,
    input  logic                         i_ready,
    input  logic                         o_collision,
    input  logic [sxfb_pkg::PIX_W-1:0]   o_pixel_row
);
    import sxfb_pkg::*;

    // reset drops the result valid
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pixel_row)
                                && $stable(o_collision))
        else $error("stalled result changed");

    // a free output side never blocks the input side
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid || i_ready |-> o_ready)
        else $error("input stalled with free result register");

    // an accept is followed by o_valid, from this word or from a stalled older one
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |-> ##2 o_valid)
        else $error("accepted word did not reach the output");

    // columns past the frame width stay dark
    a_width_clip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_pixel_row & ~WIDTH_MASK) == '0)
        else $error("pixel lit beyond frame width");

endmodule

bind sprite_xor_frame_buffer sxfb_checker u_sxfb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_ready    (o_ready),
    .o_valid    (o_valid),
    .i_ready    (i_ready),
    .o_collision(o_collision),
    .o_pixel_row(o_pixel_row)
);

// ===== bench/fb_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fb_checker: result scoreboard for the sprite XOR frame buffer
// Keeps a shadow copy of the frame and the collision flag, predicts one
// result word per accepted request and compares each returned word with
// the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module fb_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_ready,
    input  logic [1:0]                 i_req_type,
    input  logic [7:0]                 i_start_x,
    input  logic [7:0]                 i_start_y,
    input  logic [3:0]                 i_row_offset,
    input  logic [7:0]                 i_sprite_byte,
    input  logic [4:0]                 i_read_row,
    input  logic                       i_out_valid,
    input  logic                       i_out_ready,
    input  logic                       i_collision,
    input  logic [sxfb_pkg::PIX_W-1:0] i_pixel_row,
    output int                         o_fail_count,
    output int                         o_outstanding
);
    import sxfb_pkg::*;

    typedef struct packed {
        logic             collision;
        logic [PIX_W-1:0] pixel_row;
    } t_fb_result;

    logic [PIX_W-1:0] shadow_rows [FRAME_HEIGHT];
    logic             shadow_hit;
    t_fb_result       due_words [$];
    int               mismatch_total = 0;

    // Apply one request to the shadow frame and return the word it should produce.
    function automatic t_fb_result serve_request(
        input logic [1:0] req,
        input logic [7:0] sx,
        input logic [7:0] sy,
        input logic [3:0] off,
        input logic [7:0] bits,
        input logic [4:0] rr
    );
        t_fb_result res;
        int         x0;
        int         y;
        int         col;
        res = '0;
        case (req)
            REQ_CLEAR: begin
                for (int r = 0; r < FRAME_HEIGHT; r++) begin
                    shadow_rows[r] = '0;
                end
            end
            REQ_DRAW: begin
                x0 = int'(sx) % FRAME_WIDTH;
                y  = (int'(sy) % FRAME_HEIGHT) + int'(off);
                if (off == 4'd0) begin
                    shadow_hit = 1'b0;
                end
                // rows below the bottom edge are dropped whole
                if (y < FRAME_HEIGHT) begin
                    for (int k = 0; k < SPRITE_BITS; k++) begin
                        col = x0 + k;
                        if (col >= FRAME_WIDTH) begin
                            break;
                        end
                        if (bits[SPRITE_BITS-1-k]) begin
                            if (shadow_rows[y][PIX_W-1-col]) begin
                                shadow_hit = 1'b1;
                            end
                            shadow_rows[y][PIX_W-1-col] = ~shadow_rows[y][PIX_W-1-col];
                        end
                    end
                end
                res.collision = shadow_hit;
            end
            REQ_READ: begin
                if (int'(rr) < FRAME_HEIGHT) begin
                    res.pixel_row = shadow_rows[rr];
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_fb_result want;
        if (!i_rst_n) begin
            for (int r = 0; r < FRAME_HEIGHT; r++) begin
                shadow_rows[r] = '0;
            end
            shadow_hit = 1'b0;
            due_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (due_words.size() == 0) begin
                    $display("%0t: unexpected result word: collision %0b pixel_row %h",
                             $time, i_collision, i_pixel_row);
                    mismatch_total++;
                end else begin
                    want = due_words.pop_front();
                    if (i_collision !== want.collision) begin
                        $display("%0t: collision mismatch: expected %0b actual %0b",
                                 $time, want.collision, i_collision);
                        mismatch_total++;
                    end
                    if (i_pixel_row !== want.pixel_row) begin
                        $display("%0t: pixel_row mismatch: expected %h actual %h",
                                 $time, want.pixel_row, i_pixel_row);
                        mismatch_total++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                due_words.push_back(serve_request(i_req_type, i_start_x, i_start_y,
                                                  i_row_offset, i_sprite_byte, i_read_row));
            end
        end
        o_fail_count  <= mismatch_total;
        o_outstanding <= due_words.size();
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the sprite XOR frame buffer
// Drives a directed set of clears, draws and reads, then random sprites,
// replays, reads and noise words with bursty input and a stalling output.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;
    import sxfb_pkg::*;

    // request code the block does not define; it must be ignored
    localparam logic [1:0] REQ_SPARE = 2'd3;

    localparam int RANDOM_WORDS  = 1850;
    // generous bound for ~1900 words with gaps and stalls
    localparam int LIMIT_CYCLES  = 300000;
    // extra wait after the last result word has been checked
    localparam int DRAIN_CYCLES  = 8;
    // long output hold-off (LONG_HOLD), started once HOLD_AFTER words have gone in
    localparam int LONG_HOLD     = 200;
    localparam int HOLD_AFTER    = 400;

    typedef enum logic [1:0] {
        RX_FREE,
        RX_CHOPPY,
        RX_STARVED
    } t_rx_mode;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_valid       = 1'b0;
    logic [1:0]  i_req_type    = '0;
    logic [7:0]  i_start_x     = '0;
    logic [7:0]  i_start_y     = '0;
    logic [3:0]  i_row_offset  = '0;
    logic [7:0]  i_sprite_byte = '0;
    logic        i_last_row    = 1'b0;
    logic [4:0]  i_read_row    = '0;
    logic        i_ready       = 1'b0;
    logic        o_ready;
    logic        o_valid;
    logic        o_collision;
    logic [63:0] o_pixel_row;

    int fail_count;
    int outstanding;
    int words_sent     = 0;
    int burst_left     = 1;
    int cycle_count    = 0;
    bit long_hold_done = 1'b0;

    // last fresh sprite, kept so it can be drawn again to erase itself
    logic [7:0] prev_sx;
    logic [7:0] prev_sy;
    logic [7:0] prev_bytes [16];
    int         prev_rows  = 0;

    always #5 i_clk = ~i_clk;

    sprite_xor_frame_buffer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_row_offset  (i_row_offset),
        .i_sprite_byte (i_sprite_byte),
        .i_last_row    (i_last_row),
        .i_read_row    (i_read_row),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_collision   (o_collision),
        .o_pixel_row   (o_pixel_row)
    );

    fb_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_ready    (o_ready),
        .i_req_type    (i_req_type),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_row_offset  (i_row_offset),
        .i_sprite_byte (i_sprite_byte),
        .i_read_row    (i_read_row),
        .i_out_valid   (o_valid),
        .i_out_ready   (i_ready),
        .i_collision   (o_collision),
        .i_pixel_row   (o_pixel_row),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Offer one request word and hold it until the block takes it. The caller
    // must be sitting at a rising edge. At the end of a burst drop valid for a
    // random gap; a zero gap keeps valid high so the next word follows at once.
    task automatic send_word(
        input logic [1:0] req,
        input logic [7:0] sx,
        input logic [7:0] sy,
        input logic [3:0] off,
        input logic [7:0] bits,
        input logic       last,
        input logic [4:0] rr
    );
        int idle_len;
        i_valid       <= 1'b1;
        i_req_type    <= req;
        i_start_x     <= sx;
        i_start_y     <= sy;
        i_row_offset  <= off;
        i_sprite_byte <= bits;
        i_last_row    <= last;
        i_read_row    <= rr;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            idle_len   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (idle_len > 0) begin
                i_valid <= 1'b0;
                repeat (idle_len) @(posedge i_clk);
            end
        end
    endtask

    // Draw a whole sprite: a fresh one, or a replay of the previous one, which
    // erases it again and raises the collision flag.
    task automatic draw_sprite();
        if (prev_rows == 0 || $urandom_range(0, 3) != 0) begin
            prev_sx   = 8'($urandom);
            prev_sy   = 8'($urandom);
            prev_rows = ($urandom_range(0, 7) == 0) ? $urandom_range(6, 16)
                                                    : $urandom_range(1, 5);
            for (int r = 0; r < 16; r++) begin
                prev_bytes[r] = 8'($urandom);
            end
        end
        for (int r = 0; r < prev_rows; r++) begin
            send_word(REQ_DRAW, prev_sx, prev_sy, 4'(r), prev_bytes[r],
                      r == prev_rows - 1, 5'($urandom));
        end
    endtask

    // Output side: alternate free-flowing, choppy and starved stretches.
    // Once, hold ready low for a long stretch so the block backs up.
    initial begin
        t_rx_mode mode;
        int       span;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            if (!long_hold_done && words_sent >= HOLD_AFTER) begin
                i_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold_done = 1'b1;
            end
            mode = t_rx_mode'($urandom_range(0, 2));
            span = $urandom_range(10, 80);
            repeat (span) begin
                case (mode)
                    RX_FREE:    i_ready <= 1'b1;
                    RX_CHOPPY:  i_ready <= 1'($urandom);
                    default:    i_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    // Watchdog: end the run if the traffic hangs.
    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    initial begin
        int directed_words;
        int pick;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd0);   // freshly reset row
        send_word(REQ_DRAW,  8'h00, 8'h00, 4'h0, 8'hFF, 1'b1, 5'd0);
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd0);
        send_word(REQ_DRAW,  8'h00, 8'h00, 4'h0, 8'h81, 1'b1, 5'd0);   // erase both ends
        // wrapped start, empty row: flag carries over from row 0
        send_word(REQ_DRAW,  8'd64, 8'd32, 4'h1, 8'h00, 1'b1, 5'd0);
        // right edge: only four of eight pixels land
        send_word(REQ_DRAW,  8'd60, 8'd5,  4'h0, 8'hFF, 1'b0, 5'd0);
        send_word(REQ_DRAW,  8'hFF, 8'hFF, 4'h0, 8'h80, 1'b0, 5'd0);   // last column, last row
        // bottom edge: row lands past the frame and is dropped
        send_word(REQ_DRAW,  8'hFF, 8'hFF, 4'h1, 8'hFF, 1'b1, 5'd0);
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd31);
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd5);
        send_word(REQ_DRAW,  8'h00, 8'd17, 4'hF, 8'h01, 1'b1, 5'd0);   // off the bottom
        send_word(REQ_DRAW,  8'h08, 8'd16, 4'hF, 8'hAA, 1'b1, 5'd0);   // exactly the last row
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd31);
        send_word(REQ_DRAW,  8'h00, 8'h00, 4'h0, 8'h7E, 1'b1, 5'd0);   // hits lit pixels
        send_word(REQ_CLEAR, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 5'd31);
        // clear keeps the flag: an empty continuation row still reports it
        send_word(REQ_DRAW,  8'h00, 8'h00, 4'h1, 8'h00, 1'b1, 5'd0);
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd0);
        send_word(REQ_SPARE, 8'hFF, 8'hFF, 4'hF, 8'hFF, 1'b1, 5'd31);
        send_word(REQ_SPARE, 8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd0);
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd31);
        send_word(REQ_DRAW,  8'd200, 8'd100, 4'h0, 8'h01, 1'b0, 5'd0);
        send_word(REQ_READ,  8'h00, 8'h00, 4'h0, 8'h00, 1'b0, 5'd4);
        directed_words = words_sent;

        // random part: mostly whole sprites and reads, some clears and noise
        while (words_sent < directed_words + RANDOM_WORDS) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                draw_sprite();
            end else if (pick < 85) begin
                send_word(REQ_READ, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 5'($urandom));
            end else if (pick < 87) begin
                send_word(REQ_CLEAR, 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 5'($urandom));
            end else if (pick < 93) begin
                // noise: any request code, spare one included
                send_word(2'($urandom), 8'($urandom), 8'($urandom), 4'($urandom),
                          8'($urandom), 1'($urandom), 5'($urandom));
            end else begin
                // broken sprite: a continuation row with no opening row
                send_word(REQ_DRAW, 8'($urandom), 8'($urandom), 4'($urandom_range(1, 15)),
                          8'($urandom), 1'($urandom), 5'($urandom));
            end
        end

        // drain: drop valid, let the last accept reach the checker, then wait it out
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && outstanding == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
